// ===== rtl/swo_pkg.sv =====
// Package: shared types and constants of the skewed waveform oscillator.
`timescale 1ns / 1ps
package swo_pkg;

  localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_PHASE_FRAC_BITS  = 16;

  localparam int unsigned SR_W    = 18;
  localparam int unsigned WAVE_W  = 2;
  localparam int unsigned FREQ_W  = 23;
  localparam int unsigned VOL_W   = 15;
  localparam int unsigned SKEW_W  = 16;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [SR_W-1:0]   SR_RESET  = 18'd48000;
  localparam logic [FREQ_W-1:0] FREQ_MIN  = 23'd256;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE  = 2'd0,
    WAVE_TRI   = 2'd1,
    WAVE_PULSE = 2'd2,
    WAVE_OFF   = 2'd3
  } wave_e;

  typedef enum logic {
    REG_SAMPLE_RATE = 1'b0,
    REG_WAVEFORM    = 1'b1
  } reg_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_PCHK,
    ST_PADV,
    ST_PWRAP,
    ST_MUL,
    ST_REST,
    ST_DIFF,
    ST_ADDR,
    ST_DIV2,
    ST_WAVE,
    ST_ROMW,
    ST_MIX,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [SR_W-1:0] sample_rate;
    wave_e           waveform;
  } cfg_t;

endpackage

// ===== rtl/swo_if.sv =====
// Interfaces: input item channel and result item channel.
`timescale 1ns / 1ps
interface swo_in_if;
  logic                               valid;
  logic                               ready;
  logic [swo_pkg::FREQ_W-1:0]         frequency;
  logic [swo_pkg::VOL_W-1:0]          volume;
  logic signed [swo_pkg::SKEW_W-1:0]  skew;

  modport source (output valid, frequency, volume, skew, input ready);
  modport sink   (input valid, frequency, volume, skew, output ready);
endinterface

interface swo_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [swo_pkg::SMP_W-1:0]  sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// ===== rtl/skewed_waveform_oscillator_core.sv =====
// Top level: sequencer and datapath of the skewed waveform oscillator.
`timescale 1ns / 1ps
// One input item yields one signed Q1.15 sample. The item runs through a
// sequencer around a single add/subtract unit: a restoring division for the
// period (18+PHASE_FRAC_BITS+17 steps), phase advance and wrap, a shift-add
// multiply for the split point (17 steps), and for sine or triangle a second
// restoring division of the same length; sine then takes a table lookup, and
// every item ends with the gain. A zero period skips to the gain with a zero
// wave and resets the phase. Input ready is high only while the sequencer is
// idle; a finished sample waits in an output register, so the next item can
// enter meanwhile.
module skewed_waveform_oscillator_core #(
  parameter int unsigned SINE_TABLE_DEPTH = swo_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int unsigned PHASE_FRAC_BITS  = swo_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  swo_in_if.sink                      in_s,
  swo_out_if.source                   out_s,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swo_pkg::APB_AW-1:0]  paddr,
  input  logic [swo_pkg::APB_DW-1:0]  pwdata,
  output logic [swo_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned PB  = swo_pkg::SR_W + PHASE_FRAC_BITS;
  localparam int unsigned DW  = PB + 17;
  localparam int unsigned UW  = DW + 1;
  localparam int unsigned CW  = $clog2(DW);
  localparam int unsigned IW  = $clog2(SINE_TABLE_DEPTH);
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(SINE_TABLE_DEPTH);

  swo_pkg::cfg_t   cfg;
  swo_pkg::state_e state_q, state_d;

  logic [PB-1:0]    phase_q, period_q, split_q, rest_q, dsr_q;
  logic [PB:0]      diff_q;
  logic [DW-1:0]    dvd_q;
  logic [PB-1:0]    rem_q;
  logic [UW-1:0]    acc_q;
  logic [CW-1:0]    cnt_q;
  logic             lt_q;
  logic [16:0]      p16_q;
  logic [swo_pkg::VOL_W-1:0] vol_q;
  swo_pkg::wave_e   wave_q;
  logic signed [16:0] w_q;
  logic signed [32:0] prod_q;
  logic signed [swo_pkg::SMP_W-1:0] sample_q;
  logic             out_valid_q;

  swo_pkg::alu_op_e alu_op;
  logic [UW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_neg;

  logic             in_acc, out_free, div_last, mul_last;
  logic [PB:0]      div_trial;
  logic [16+IW:0]   idx_prod;
  logic signed [swo_pkg::SMP_W-1:0] rom_data;
  logic [swo_pkg::FREQ_W-1:0] freq_cl;
  logic signed [33:0] mix_sum;
  logic signed [18:0] mix_sh;

  swo_apb u_apb (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  swo_alu #(.W(UW)) u_alu (
    .op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .res_o(alu_res), .neg_o(alu_neg)
  );

  assign idx_prod = dvd_q[15:0] * DEPTH_W;

  swo_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk_i, .addr_i(idx_prod[16+IW-1:16]), .data_o(rom_data)
  );

  assign in_s.ready  = (state_q == swo_pkg::ST_IDLE);
  assign in_acc      = in_s.valid & in_s.ready;
  assign out_free    = !out_valid_q || out_s.ready;
  assign out_s.valid = out_valid_q;
  assign out_s.sample = sample_q;
  assign div_last    = (cnt_q == CW'(DW - 1));
  assign mul_last    = (cnt_q == CW'(16));
  assign div_trial   = {rem_q, dvd_q[DW-1]};
  assign freq_cl     = (in_s.frequency < swo_pkg::FREQ_MIN) ? swo_pkg::FREQ_MIN
                                                            : in_s.frequency;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swo_pkg::ST_IDLE:  if (in_acc) state_d = swo_pkg::ST_DIV1;
      swo_pkg::ST_DIV1:  if (div_last) state_d = swo_pkg::ST_PCHK;
      swo_pkg::ST_PCHK:  state_d = (dvd_q[PB-1:0] == '0) ? swo_pkg::ST_MIX
                                                         : swo_pkg::ST_PADV;
      swo_pkg::ST_PADV:  state_d = swo_pkg::ST_PWRAP;
      swo_pkg::ST_PWRAP: state_d = swo_pkg::ST_MUL;
      swo_pkg::ST_MUL:   if (mul_last) state_d = swo_pkg::ST_REST;
      swo_pkg::ST_REST:  state_d = swo_pkg::ST_DIFF;
      swo_pkg::ST_DIFF:  state_d = (wave_q == swo_pkg::WAVE_SINE ||
                                    wave_q == swo_pkg::WAVE_TRI) ? swo_pkg::ST_ADDR
                                                                 : swo_pkg::ST_MIX;
      swo_pkg::ST_ADDR:  state_d = swo_pkg::ST_DIV2;
      swo_pkg::ST_DIV2:  if (div_last) state_d = swo_pkg::ST_WAVE;
      swo_pkg::ST_WAVE:  state_d = (wave_q == swo_pkg::WAVE_SINE) ? swo_pkg::ST_ROMW
                                                                  : swo_pkg::ST_MIX;
      swo_pkg::ST_ROMW:  state_d = swo_pkg::ST_MIX;
      swo_pkg::ST_MIX:   state_d = swo_pkg::ST_HOLD;
      swo_pkg::ST_HOLD:  if (out_free) state_d = swo_pkg::ST_IDLE;
      default:           state_d = swo_pkg::ST_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    alu_op = swo_pkg::ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      swo_pkg::ST_DIV1, swo_pkg::ST_DIV2: begin
        alu_a = UW'(div_trial);
        alu_b = UW'(dsr_q);
      end
      swo_pkg::ST_PADV: begin
        alu_op = swo_pkg::ALU_ADD;
        alu_a  = UW'(phase_q);
        alu_b  = UW'(1) << PHASE_FRAC_BITS;
      end
      swo_pkg::ST_PWRAP: begin
        alu_a = UW'(phase_q);
        alu_b = UW'(period_q);
      end
      swo_pkg::ST_MUL: begin
        alu_op = swo_pkg::ALU_ADD;
        alu_a  = acc_q << 1;
        alu_b  = p16_q[5'(16 - cnt_q)] ? UW'(period_q) : '0;
      end
      swo_pkg::ST_REST: begin
        alu_a = UW'(period_q);
        alu_b = UW'(acc_q[PB+15:16]);
      end
      swo_pkg::ST_DIFF: begin
        alu_a = UW'(phase_q);
        alu_b = UW'(split_q);
      end
      swo_pkg::ST_ADDR: begin
        alu_op = swo_pkg::ALU_ADD;
        alu_a  = UW'(diff_q);
        alu_b  = UW'(rest_q);
      end
      default: begin
        alu_op = swo_pkg::ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swo_pkg::ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      // load a finished sample, else drop the one taken downstream
      if (state_q == swo_pkg::ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        swo_pkg::ST_IDLE: cnt_q <= '0;
        swo_pkg::ST_DIV1, swo_pkg::ST_DIV2, swo_pkg::ST_MUL:
          cnt_q <= (div_last || (state_q == swo_pkg::ST_MUL && mul_last)) ? '0
                                                                           : cnt_q + 1'b1;
        swo_pkg::ST_PCHK: if (dvd_q[PB-1:0] == '0) phase_q <= '0;
        swo_pkg::ST_PADV: phase_q <= alu_res[PB-1:0];
        swo_pkg::ST_PWRAP: if (!alu_neg) phase_q <= alu_res[PB-1:0];
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      swo_pkg::ST_IDLE: begin
        if (in_acc) begin
          vol_q  <= in_s.volume;
          wave_q <= cfg.waveform;
          p16_q  <= (in_s.skew == -16'sd32768) ? 17'd1
                                              : {1'b0, ~in_s.skew[15], in_s.skew[14:0]};
          dvd_q  <= DW'(cfg.sample_rate) << (PHASE_FRAC_BITS + 8);
          dsr_q  <= PB'(freq_cl);
          rem_q  <= '0;
        end
      end
      swo_pkg::ST_DIV1, swo_pkg::ST_DIV2: begin
        rem_q <= alu_neg ? div_trial[PB-1:0] : alu_res[PB-1:0];
        dvd_q <= {dvd_q[DW-2:0], !alu_neg};
      end
      swo_pkg::ST_PCHK: begin
        period_q <= dvd_q[PB-1:0];
        acc_q    <= '0;
        w_q      <= '0;
      end
      swo_pkg::ST_MUL: acc_q <= alu_res;
      swo_pkg::ST_REST: begin
        split_q <= acc_q[PB+15:16];
        rest_q  <= alu_res[PB-1:0];
      end
      swo_pkg::ST_DIFF: begin
        lt_q   <= alu_neg;
        diff_q <= alu_res[PB:0];
        case (wave_q)
          swo_pkg::WAVE_PULSE: w_q <= alu_neg ? 17'sd32768 : -17'sd32768;
          default:             w_q <= '0;
        endcase
      end
      swo_pkg::ST_ADDR: begin
        rem_q <= '0;
        dsr_q <= lt_q ? split_q : rest_q;
        if (wave_q == swo_pkg::WAVE_SINE) begin
          dvd_q <= lt_q ? (DW'(phase_q) << 15) : (DW'(alu_res[PB:0]) << 15);
        end else begin
          dvd_q <= lt_q ? (DW'(phase_q) << 16) : (DW'(diff_q) << 16);
        end
      end
      swo_pkg::ST_WAVE: begin
        if (lt_q) begin
          w_q <= $signed({1'b0, dvd_q[15:0]}) - 17'sd32768;
        end else if (dvd_q > DW'(65536)) begin
          w_q <= -17'sd32768;
        end else begin
          w_q <= 17'sd32768 - $signed(dvd_q[16:0]);
        end
      end
      swo_pkg::ST_ROMW: w_q <= 17'(rom_data);
      swo_pkg::ST_MIX:  prod_q <= 33'(w_q) * 33'($signed({1'b0, vol_q}));
      swo_pkg::ST_HOLD: begin
        if (out_free) begin
          if (mix_sh > 19'sd32767) begin
            sample_q <= 16'sd32767;
          end else if (mix_sh < -19'sd32768) begin
            sample_q <= -16'sd32768;
          end else begin
            sample_q <= mix_sh[15:0];
          end
        end
      end
      default: begin
        w_q <= w_q;
      end
    endcase
  end

  // round half up and scale down by 2^15
  assign mix_sum = 34'(prod_q) + 34'sd16384;
  assign mix_sh  = 19'(mix_sum >>> 15);

endmodule

// ===== rtl/swo_alu.sv =====
// Shared add/subtract unit used by both divides, the split-point multiply and the phase steps.
`timescale 1ns / 1ps
module swo_alu #(
  parameter int unsigned W = 52
) (
  input  swo_pkg::alu_op_e op_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [W-1:0]     res_o,
  output logic             neg_o
);

  always_comb begin
    case (op_i)
      swo_pkg::ALU_ADD: res_o = a_i + b_i;
      swo_pkg::ALU_SUB: res_o = a_i - b_i;
      default:          res_o = a_i + b_i;
    endcase
  end

  // operands stay below half range, so the top bit flags a borrow
  assign neg_o = res_o[W-1];

endmodule

// ===== rtl/swo_sine_rom.sv =====
// Sine table ROM with registered read data.
`timescale 1ns / 1ps
module swo_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = swo_pkg::DEF_SINE_TABLE_DEPTH,
  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                             clk_i,
  input  logic [IW-1:0]                    addr_i,
  output logic signed [swo_pkg::SMP_W-1:0] data_o
);

  typedef logic signed [swo_pkg::SMP_W-1:0] rom_t [SINE_TABLE_DEPTH];

  function automatic logic signed [swo_pkg::SMP_W-1:0] sine_entry(longint unsigned i);
    longint unsigned n, quad, r, num, x, x2, term, v, prod;
    longint          sum;
    n    = i * 4;
    quad = n / SINE_TABLE_DEPTH;
    r    = n % SINE_TABLE_DEPTH;
    num  = quad[0] ? SINE_TABLE_DEPTH - r : r;
    x    = (num * 64'd1686629713) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      prod = (term * x2) >> 30;
      // divide by (2k)(2k+1) for the next odd power
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        default: term = prod / 64'd156;
      endcase
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return (quad >= 2) ? -16'(v) : 16'(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t[i] = sine_entry(longint'(i));
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk_i) begin
    data_o <= ROM[addr_i];
  end

endmodule

// ===== rtl/swo_apb.sv =====
// APB configuration registers: sample rate and waveform select.
`timescale 1ns / 1ps
module swo_apb (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swo_pkg::APB_AW-1:0]  paddr,
  input  logic [swo_pkg::APB_DW-1:0]  pwdata,
  output logic [swo_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output swo_pkg::cfg_t               cfg_o
);

  swo_pkg::cfg_t cfg_q;
  logic          wr_en;
  swo_pkg::reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = swo_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate <= swo_pkg::SR_RESET;
      cfg_q.waveform    <= swo_pkg::WAVE_SINE;
    end else if (wr_en) begin
      case (reg_sel)
        swo_pkg::REG_SAMPLE_RATE: cfg_q.sample_rate <= pwdata[swo_pkg::SR_W-1:0];
        swo_pkg::REG_WAVEFORM:    cfg_q.waveform <= swo_pkg::wave_e'(pwdata[swo_pkg::WAVE_W-1:0]);
        default:                  cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      swo_pkg::REG_SAMPLE_RATE: prdata = swo_pkg::APB_DW'(cfg_q.sample_rate);
      swo_pkg::REG_WAVEFORM:    prdata = swo_pkg::APB_DW'(cfg_q.waveform);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/swo_checker.sv =====
// Port-level checker for the oscillator core, bound to the top level.
`timescale 1ns / 1ps
module swo_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [swo_pkg::SMP_W-1:0] out_sample,
  input logic pready
);

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // a result never appears in the cycle after its item is accepted
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result rose right after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled result dropped or changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind skewed_waveform_oscillator_core swo_checker u_swo_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .out_sample (out_s.sample),
  .pready     (pready)
);
